// ----- rtl/core/sld_pkg.sv -----
// sld_pkg: shared types and constants for the square-law power detector
// no dependencies

package sld_pkg;

	// line store geometry
	localparam int LINE_DEPTH = 4096;
	localparam int POS_W      = $clog2(LINE_DEPTH);
	localparam int LEN_W      = POS_W + 1;

	// datapath widths
	localparam int SAMPLE_W   = 16;
	localparam int STORE_W    = 2 * SAMPLE_W;
	localparam int POWER_W    = STORE_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEN_W;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POL_COUNT   = 2'd2;

	// detect modes
	localparam logic MODE_PPQQ      = 1'b0;
	localparam logic MODE_INTENSITY = 1'b1;

	// per-sample control that travels with the data down the pipeline
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             last;
		logic             store_wr;
		logic             store_add;
		logic             emit;
	} item_tag_t;

endpackage

// ----- rtl/core/square_law_detector_core.sv -----
// square_law_detector_core: square-law power detector with dual-pol intensity sum
// depends on sld_pkg, sld_seq, sld_line_store
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  sample_re, sample_im
//   out      source     out_valid/out_ready  power, line_end
//   cfg      sink       cfg_write            cfg_index, cfg_data
//
// one sample accepted per cycle unless a held result stalls the pipeline
// stages: input register, squares and line store read, sum into output register
// a held result stalls all stages together; in_ready is low only then
// reset clears control and position counters; the line store is not cleared,
// pol-0 entries are always written before the pol-1 line reads them

module square_law_detector_core
	import sld_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_re,
	input  logic signed [SAMPLE_W-1:0] sample_im,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [POWER_W-1:0]         power,
	output logic                       line_end
);

	logic                       en;
	logic                       accept;
	item_tag_t                  tag;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] re_s1;
	logic signed [SAMPLE_W-1:0] im_s1;
	item_tag_t                  tag_s1;

	logic signed [STORE_W-1:0]  sq_re;
	logic signed [STORE_W-1:0]  sq_im;
	logic [STORE_W-1:0]         pwr;

	logic                       valid_s2;
	logic [STORE_W-1:0]         pwr_s2;
	item_tag_t                  tag_s2;
	logic [STORE_W-1:0]         store_rd;

	logic                       out_valid_q;
	logic [POWER_W-1:0]         power_q;
	logic                       line_end_q;

	// pipeline advances when the output register is free or being drained
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;

	sld_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.tag       (tag)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			re_s1  <= sample_re;
			im_s1  <= sample_im;
			tag_s1 <= tag;
		end
	end

	// squares and their sum, at most 2^31
	assign sq_re = re_s1 * re_s1;
	assign sq_im = im_s1 * im_s1;
	assign pwr   = unsigned'(sq_re) + unsigned'(sq_im);

	// pol-0 powers go into the line store, pol-1 reads the matching entry
	sld_line_store u_store (
		.clk     (clk),
		.wr_en   (en && valid_s1 && tag_s1.store_wr),
		.wr_addr (tag_s1.pos),
		.wr_data (pwr),
		.rd_en   (en && valid_s1 && tag_s1.store_add),
		.rd_addr (tag_s1.pos),
		.rd_data (store_rd)
	);

	// power register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			pwr_s2 <= pwr;
			tag_s2 <= tag_s1;
		end
	end

	// output register: add the stored pol-0 power in intensity mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2 && tag_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			power_q    <= {1'b0, pwr_s2} +
				(tag_s2.store_add ? {1'b0, store_rd} : POWER_W'(0));
			line_end_q <= tag_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign power     = power_q;
	assign line_end  = line_end_q;

endmodule

// ----- rtl/core/sld_seq.sv -----
// sld_seq: configuration registers and line / polarisation position counters
// depends on sld_pkg

module sld_seq
	import sld_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  advance,
	output item_tag_t             tag
);

	logic             detect_mode_q;
	logic [LEN_W-1:0] line_length_q;
	logic [1:0]       pol_count_q;
	logic [POS_W-1:0] pos_q;
	logic             pol_q;

	logic [LEN_W-1:0] len_eff;
	logic             two_pols;
	logic             intensity;
	logic             last;

	// effective line length: zero acts as one, saturate at the store depth
	always_comb begin
		if (line_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (line_length_q > LEN_W'(LINE_DEPTH)) begin
			len_eff = LEN_W'(LINE_DEPTH);
		end else begin
			len_eff = line_length_q;
		end
	end

	// decode of the current sample
	assign two_pols  = pol_count_q[1];
	assign intensity = (detect_mode_q == MODE_INTENSITY) && two_pols;
	assign last      = ({1'b0, pos_q} + LEN_W'(1)) == len_eff;

	always_comb begin
		tag.pos       = pos_q;
		tag.last      = last;
		tag.store_wr  = intensity && !pol_q;
		tag.store_add = intensity && pol_q;
		tag.emit      = !(intensity && !pol_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_mode_q <= MODE_PPQQ;
			line_length_q <= LEN_W'(1);
			pol_count_q   <= 2'd2;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DETECT_MODE: detect_mode_q <= cfg_data[0];
				REG_LINE_LENGTH: line_length_q <= cfg_data;
				REG_POL_COUNT:   pol_count_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// position counters, restarted by a write to any of the three real registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pol_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DETECT_MODE, REG_LINE_LENGTH, REG_POL_COUNT: begin
					pos_q <= '0;
					pol_q <= 1'b0;
				end
				default: ;
			endcase
		end else if (advance) begin
			if (last) begin
				pos_q <= '0;
				pol_q <= two_pols ? !pol_q : 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/sld_line_store.sv -----
// sld_line_store: one write, one registered read memory holding pol-0 powers
// depends on sld_pkg

module sld_line_store
	import sld_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [POS_W-1:0]   wr_addr,
	input  logic [STORE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [POS_W-1:0]   rd_addr,
	output logic [STORE_W-1:0] rd_data
);

	logic [STORE_W-1:0] mem [LINE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- dv/power_checker.sv -----
`timescale 1ns / 100ps
// power_checker: watches the sample, power and config channels of the detector,
// predicts every power result and compares it with what the block delivers
// depends on sld_pkg

module power_checker
	import sld_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_re,
	input  logic signed [SAMPLE_W-1:0] sample_im,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [POWER_W-1:0]         power,
	input  logic                       line_end,
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic [POWER_W-1:0] power;
		logic               line_end;
	} power_result_t;

	// shadow configuration and line position
	logic                  detect_mode_q;
	logic [CFG_DATA_W-1:0] line_length_q;
	logic [1:0]            pol_count_q;
	logic [POS_W-1:0]      sample_pos;
	logic                  pol_pos;

	// pol-0 powers kept for the intensity sum, and results still owed by the block
	logic [STORE_W-1:0]    pol0_power [LINE_DEPTH];
	power_result_t         power_fifo [$];
	int                    mismatches;

	// exact square-law power of one complex sample
	function automatic logic [POWER_W-1:0] sample_power(input logic signed [SAMPLE_W-1:0] re,
		input logic signed [SAMPLE_W-1:0] im);
		longint r_l;
		longint i_l;
		r_l = re;
		i_l = im;
		return POWER_W'(r_l * r_l + i_l * i_l);
	endfunction

	// line length as the block uses it: zero counts as one, large values saturate
	function automatic int active_length();
		if (line_length_q == 0)
			return 1;
		if (line_length_q > LINE_DEPTH)
			return LINE_DEPTH;
		return int'(line_length_q);
	endfunction

	// register write: any real register restarts the line group
	task automatic take_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_DETECT_MODE: detect_mode_q = data[0];
			REG_LINE_LENGTH: line_length_q = data;
			REG_POL_COUNT:   pol_count_q   = data[1:0];
			default:         return;
		endcase
		sample_pos = '0;
		pol_pos    = 1'b0;
	endtask

	// one accepted sample: work out its result, if any, and advance the position
	task automatic predict_power(input logic signed [SAMPLE_W-1:0] re,
		input logic signed [SAMPLE_W-1:0] im);
		int                 len;
		logic               dual;
		logic               is_last;
		logic               summing;
		logic [POWER_W-1:0] p;
		len     = active_length();
		dual    = (pol_count_q >= 2);
		summing = (detect_mode_q == MODE_INTENSITY) && dual;
		p       = sample_power(re, im);
		is_last = (int'(sample_pos) + 1 == len);
		if (summing && !pol_pos) begin
			// pol-0 power waits for its pol-1 partner, nothing comes out
			pol0_power[sample_pos] = p[STORE_W-1:0];
		end else begin
			if (summing)
				p = p + POWER_W'(pol0_power[sample_pos]);
			power_fifo.push_back({p, is_last});
		end
		if (is_last) begin
			sample_pos = '0;
			pol_pos    = dual ? !pol_pos : 1'b0;
		end else begin
			sample_pos = sample_pos + 1'b1;
		end
	endtask

	always @(posedge clk) begin : watch
		power_result_t want;
		if (!arst_n) begin
			detect_mode_q = MODE_PPQQ;
			line_length_q = 1;
			pol_count_q   = 2;
			sample_pos    = '0;
			pol_pos       = 1'b0;
			power_fifo.delete();
			mismatches    = 0;
		end else begin
			if (cfg_write)
				take_write(cfg_index, cfg_data);
			// result transaction against the oldest prediction
			if (out_valid && out_ready) begin
				if (power_fifo.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual power %0d line_end %0b",
						$time, power, line_end);
					mismatches++;
				end else begin
					want = power_fifo.pop_front();
					if (power !== want.power) begin
						$display("%0t: power mismatch, expected %0d, actual %0d",
							$time, want.power, power);
						mismatches++;
					end
					if (line_end !== want.line_end) begin
						$display("%0t: line_end mismatch, expected %0b, actual %0b",
							$time, want.line_end, line_end);
						mismatches++;
					end
				end
			end
			// sample transaction
			if (in_valid && in_ready)
				predict_power(sample_re, sample_im);
		end
		fail_count <= mismatches;
		pending    <= power_fifo.size();
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// tb: stimulus, flow control and verdict for square_law_detector_core
// depends on sld_pkg, square_law_detector_core and power_checker

module tb;
	import sld_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 100;
	localparam int LONG_ITEMS    = 96;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_re = '0;
	logic signed [SAMPLE_W-1:0] sample_im = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [POWER_W-1:0]         power;
	logic                       line_end;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;
	int cycles        = 0;

	square_law_detector_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.power     (power),
		.line_end  (line_end)
	);

	power_checker power_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_re  (sample_re),
		.sample_im  (sample_im),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.power      (power),
		.line_end   (line_end),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// one sample transaction, with a random gap in front
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
		input logic signed [SAMPLE_W-1:0] im);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		sample_re <= re;
		sample_im <= im;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// all three registers; unused upper data bits carry noise
	task automatic configure(input logic mode, input logic [CFG_DATA_W-1:0] len,
		input logic [1:0] pols);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom());
		write_reg(REG_DETECT_MODE, {junk[CFG_DATA_W-1:1], mode});
		junk = CFG_DATA_W'($urandom());
		write_reg(REG_LINE_LENGTH, len);
		write_reg(REG_POL_COUNT, {junk[CFG_DATA_W-1:2], pols});
	endtask

	// stop sending until every owed result is out and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sample part biased toward the extremes
	function automatic logic signed [SAMPLE_W-1:0] pick_part();
		case ($urandom_range(0, 7))
			0:       return SAMPLE_MIN;
			1:       return SAMPLE_MAX;
			2:       return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// mostly short lines, now and then a zero or a longer one
	function automatic logic [CFG_DATA_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_DATA_W'($urandom_range(17, 64));
			default: return CFG_DATA_W'($urandom_range(1, 16));
		endcase
	endfunction

	// stimulus and verdict
	initial begin
		logic                  mode;
		logic [CFG_DATA_W-1:0] len;
		logic [1:0]            pols;
		int                    eff_len;
		int                    eff_pols;
		int                    group_len;
		int                    items;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// separate polarisations: field extremes and line ends
		configure(MODE_PPQQ, 4, 2);
		send_sample(SAMPLE_MIN, SAMPLE_MIN);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(0, 0);
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		send_sample(1, -1);
		send_sample(-1, 0);
		send_sample(SAMPLE_MAX, SAMPLE_MIN);
		send_sample(0, SAMPLE_MIN);
		drain();

		// intensity sum reaching the top of the power range; spare index leaves the line alone
		configure(MODE_INTENSITY, 3, 2);
		send_sample(SAMPLE_MIN, SAMPLE_MIN);
		send_sample(0, 0);
		send_sample(5, -7);
		drain();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
		send_sample(SAMPLE_MIN, SAMPLE_MIN);
		send_sample(0, 0);
		send_sample(-1, -1);
		drain();

		// intensity with a single polarisation emits every power
		configure(MODE_INTENSITY, 2, 1);
		send_sample(SAMPLE_MAX, 3);
		send_sample(-2, SAMPLE_MIN);
		send_sample(7, 7);
		drain();

		// zero line length and zero pol count
		configure(MODE_PPQQ, 0, 0);
		send_sample(SAMPLE_MIN, 1);
		send_sample(2, SAMPLE_MAX);
		drain();

		// pol count of three acts as two, with single-sample lines
		configure(MODE_INTENSITY, 1, 3);
		send_sample(100, -200);
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(-3, 4);
		drain();

		// head of a line at the largest length or a saturated one: no early line end
		len = $urandom_range(0, 1) ? CFG_DATA_W'(LINE_DEPTH)
			: CFG_DATA_W'($urandom_range(LINE_DEPTH + 1, (1 << CFG_DATA_W) - 1));
		configure(MODE_PPQQ, len, 2);
		for (int n = 0; n < LONG_ITEMS; n++)
			send_sample(pick_part(), pick_part());
		drain();

		// random phases of whole line groups, sometimes with a broken tail
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 67; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 67; end
				default: begin send_idle_pct = 28; stall_pct = 28; end
			endcase
			mode = $urandom_range(0, 1) ? MODE_INTENSITY : MODE_PPQQ;
			len  = pick_len();
			pols = 2'($urandom_range(0, 3));
			// long hold-off phase needs results to back up the pipeline
			if (ph == 1)
				mode = MODE_PPQQ;
			configure(mode, len, pols);
			eff_len   = (len == 0) ? 1 : int'(len);
			eff_pols  = (pols == 0) ? 1 : ((pols == 3) ? 2 : int'(pols));
			group_len = eff_len * eff_pols;
			items     = (PHASE_ITEMS / group_len + 1) * group_len;
			if ($urandom_range(0, 3) == 0)
				items += $urandom_range(1, group_len);
			for (int n = 0; n < items; n++) begin
				if (ph == 1 && n == 10)
					hold_req = 1'b1;
				if (ph == 2 && n == items / 2)
					drain();
				send_sample(pick_part(), pick_part());
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/sld_pkg.sv
rtl/core/sld_seq.sv
rtl/core/sld_line_store.sv
rtl/core/square_law_detector_core.sv
dv/power_checker.sv
dv/tb.sv
